// ----- rtl/assert_macros.svh -----
// assertion helper macros shared by the deframer rtl
// depends on clk_i and rst_ni being visible in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked on every rising edge outside reset
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("deframer assertion failed");

// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, cond) \
  `ASSERT_CLK(lbl, !(cond))

`else

`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, cond)

`endif

`endif

// ----- rtl/lpfd_pkg.sv -----
// shared types and constants for the length-prefixed frame deframer
// no dependencies
package lpfd_pkg;

  // result kinds
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_BADLEN  = 2'd2
  } kind_e;

  // frame layout
  localparam logic [31:0] MinFrameLen = 32'd10;
  localparam logic [31:0] TrailerLen  = 32'd2;
  localparam logic [31:0] HeaderLen   = 32'd8;
  localparam logic [31:0] MaxFrameRst = 32'hFFFF_FFFF;

  // one result request as it travels through the queue
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic [31:0] message_type;
    logic [31:0] declared_length;
  } result_t;

  // front to queue control
  typedef struct packed {
    logic push;
  } push_ctl_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } queue_sts_t;

endpackage

// ----- rtl/length_prefixed_frame_deframer.sv -----
// top level of the length-prefixed frame deframer
// depends on lpfd_pkg, lpfd_front, lpfd_queue, lpfd_back
//
// Input channel: one received byte per request on data_byte_i, taken when
// in_valid_i is high and in_stall_o is low. Each frame is a 4-byte
// little-endian total length, a 4-byte little-endian type, the payload and
// 2 ignored trailer bytes.
// Output channel: one result request per payload byte (kind 0), one at the
// last trailer byte (kind 1), and one when a declared length is below 10 or
// above max_frame_length (kind 2); taken when out_valid_o is high and
// out_stall_i is low. Header bytes and the first trailer byte give nothing.
// A result is written into the queue by the edge that takes its byte and is then
// loaded into the output register once that register is empty or being taken.
// Throughput: one byte per cycle while the queue is not full.
// When the receiver stalls, the output register holds and the queue fills;
// in_stall_o rises once the queue is full, and the front resumes as soon as
// an entry drains. Reset empties queue and output, returns to the length
// header, and sets max_frame_length to all ones. cfg_we_i writes the limit.
module length_prefixed_frame_deframer #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [31:0] message_type_o,
  output logic [31:0] declared_length_o
);
  import lpfd_pkg::*;

  push_ctl_t  push_ctl;
  result_t    push_data;
  result_t    head;
  queue_sts_t sts;
  logic       pop;

  // byte parser and classifier
  lpfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .queue_sts_i (sts),
    .push_ctl_o  (push_ctl),
    .push_data_o (push_data)
  );

  // decoupling queue
  lpfd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_ctl_i  (push_ctl),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .sts_o       (sts)
  );

  // output register
  lpfd_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .head_i            (head),
    .sts_i             (sts),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .kind_o            (kind_o),
    .payload_byte_o    (payload_byte_o),
    .message_type_o    (message_type_o),
    .declared_length_o (declared_length_o)
  );

endmodule

// ----- rtl/lpfd_front.sv -----
// front end: accepts stream bytes, tracks header/body position, classifies results
// depends on lpfd_pkg and assert_macros.svh
`include "assert_macros.svh"

module lpfd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           data_byte_i,
  input  lpfd_pkg::queue_sts_t queue_sts_i,
  output lpfd_pkg::push_ctl_t  push_ctl_o,
  output lpfd_pkg::result_t    push_data_o
);
  import lpfd_pkg::*;

  localparam logic [1:0] PhLength = 2'd0;
  localparam logic [1:0] PhType   = 2'd1;
  localparam logic [1:0] PhBody   = 2'd2;

  logic [31:0] max_len_q;
  logic [1:0]  phase_q, phase_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] len_q, len_d;
  logic [31:0] type_q, type_d;
  logic        in_fire;
  logic [31:0] len_asm;
  logic [31:0] type_asm;
  logic [31:0] len_m2;
  result_t     res;
  logic        res_vld;

  assign in_stall_o = queue_sts_i.full;
  assign in_fire    = in_valid_i && !queue_sts_i.full;

  // byte lane insertion for the little-endian header words
  always_comb begin
    len_asm  = len_q;
    type_asm = type_q;
    unique case (pos_q[1:0])
      2'd0: begin
        len_asm  = {24'd0, data_byte_i};
        type_asm = {type_q[31:8], data_byte_i};
      end
      2'd1: begin
        len_asm[15:8]  = data_byte_i;
        type_asm[15:8] = data_byte_i;
      end
      2'd2: begin
        len_asm[23:16]  = data_byte_i;
        type_asm[23:16] = data_byte_i;
      end
      2'd3: begin
        len_asm[31:24]  = data_byte_i;
        type_asm[31:24] = data_byte_i;
      end
      default: begin
        len_asm  = len_q;
        type_asm = type_q;
      end
    endcase
  end

  assign len_m2 = len_q - TrailerLen;

  // next state and result classification
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    len_d   = len_q;
    type_d  = type_q;
    res_vld = 1'b0;
    res     = '{kind: KIND_PAYLOAD, payload_byte: 8'd0,
                message_type: type_q, declared_length: len_q};
    unique case (phase_q)
      PhType: begin
        type_d = type_asm;
        pos_d  = pos_q + 32'd1;
        if (pos_q[1:0] == 2'd3) begin
          phase_d = PhBody;
        end
      end
      PhBody: begin
        pos_d = pos_q + 32'd1;
        if (pos_q < len_m2) begin
          res_vld          = 1'b1;
          res.kind         = KIND_PAYLOAD;
          res.payload_byte = data_byte_i;
        end else if (pos_q != len_m2) begin
          res_vld  = 1'b1;
          res.kind = KIND_DONE;
          phase_d  = PhLength;
          pos_d    = 32'd0;
          len_d    = 32'd0;
          type_d   = 32'd0;
        end
      end
      PhLength: begin
        len_d = len_asm;
        pos_d = pos_q + 32'd1;
        if (pos_q[1:0] == 2'd3) begin
          if (len_asm < MinFrameLen || len_asm > max_len_q) begin
            res_vld              = 1'b1;
            res.kind             = KIND_BADLEN;
            res.message_type     = 32'd0;
            res.declared_length  = len_asm;
            phase_d              = PhLength;
            pos_d                = 32'd0;
            len_d                = 32'd0;
            type_d               = 32'd0;
          end else begin
            phase_d = PhType;
            type_d  = 32'd0;
          end
        end
      end
      default: begin
        // unused phase code: restart and take the byte as a first length byte
        phase_d = PhLength;
        pos_d   = 32'd1;
        len_d   = {24'd0, data_byte_i};
        type_d  = 32'd0;
      end
    endcase
  end

  assign push_ctl_o.push = in_fire && res_vld;
  assign push_data_o     = res;

  // frame tracking state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhLength;
      pos_q   <= 32'd0;
      len_q   <= 32'd0;
      type_q  <= 32'd0;
    end else if (in_fire) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      type_q  <= type_d;
    end
  end

  // maximum frame length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxFrameRst;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_data_i;
    end
  end

  `ASSERT_CLK(a_len_phase_pos, (phase_q == PhLength) |-> (pos_q < 32'd4))
  `ASSERT_CLK(a_type_phase_pos, (phase_q == PhType) |-> (pos_q >= 32'd4 && pos_q < HeaderLen))
  `ASSERT_CLK(a_body_len_ok, (phase_q == PhBody) |-> (pos_q >= HeaderLen && len_q >= MinFrameLen))

endmodule

// ----- rtl/lpfd_queue.sv -----
// short result queue between the front parser and the output stage
// depends on lpfd_pkg and assert_macros.svh
`include "assert_macros.svh"

module lpfd_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lpfd_pkg::push_ctl_t  push_ctl_i,
  input  lpfd_pkg::result_t    push_data_i,
  input  logic                 pop_i,
  output lpfd_pkg::result_t    head_o,
  output lpfd_pkg::queue_sts_t sts_o
);
  import lpfd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);
  localparam logic [PtrW-1:0] LastPtr  = PtrW'(Depth - 1);

  result_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push = push_ctl_i.push;
  assign pop  = pop_i && (cnt_q != '0);

  assign sts_o.full  = (cnt_q == DepthCnt);
  assign sts_o.empty = (cnt_q == '0);
  assign head_o      = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  `ASSERT_NEVER(a_no_push_full, push && (cnt_q == DepthCnt))
  `ASSERT_CLK(a_cnt_range, cnt_q <= DepthCnt)

endmodule

// ----- rtl/lpfd_back.sv -----
// back end: output register that hands queued results to the receiver
// depends on lpfd_pkg and assert_macros.svh
`include "assert_macros.svh"

module lpfd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lpfd_pkg::result_t    head_i,
  input  lpfd_pkg::queue_sts_t sts_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           kind_o,
  output logic [7:0]           payload_byte_o,
  output logic [31:0]          message_type_o,
  output logic [31:0]          declared_length_o
);
  import lpfd_pkg::*;

  logic    out_valid_q;
  result_t out_q;
  logic    load;

  // refill whenever the register is empty or being taken
  assign load  = !sts_i.empty && (!out_valid_q || !out_stall_i);
  assign pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= head_i;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = out_q.kind;
  assign payload_byte_o    = out_q.payload_byte;
  assign message_type_o    = out_q.message_type;
  assign declared_length_o = out_q.declared_length;

  `ASSERT_CLK(a_refill, (!sts_i.empty && !out_valid_q) |=> out_valid_q)

endmodule

// ----- tb/sv/tb_length_prefixed_frame_deframer.sv -----
`timescale 1ns / 100ps
// self-checking testbench for length_prefixed_frame_deframer: drives a byte stream,
// predicts payload, frame-end and bad-length results, and checks every output request
// depends on lpfd_pkg and the deframer rtl
module tb_length_prefixed_frame_deframer;
  import lpfd_pkg::*;

  localparam int unsigned IdleLimit     = 1000;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned SettleCycles  = 20;
  localparam int unsigned PhaseBytes    = 125;
  localparam logic [31:0] NoiseMaxLimit = 32'd1000;

  typedef enum logic [1:0] {
    HDR_LENGTH,
    HDR_TYPE,
    FRAME_BODY
  } parse_phase_e;

  // frame parser mirror plus the queue of results still owed by the block
  class deframe_scoreboard;
    parse_phase_e phase;
    logic [31:0]  byte_pos;
    logic [31:0]  frame_len;
    logic [31:0]  type_word;
    logic [31:0]  max_len;
    result_t      owed_q[$];
    int unsigned  errors;

    function new();
      max_len = MaxFrameRst;
      errors  = 0;
      restart();
    endfunction

    function void restart();
      phase     = HDR_LENGTH;
      byte_pos  = '0;
      frame_len = '0;
      type_word = '0;
    endfunction

    function bit at_boundary();
      return phase == HDR_LENGTH && byte_pos == 0;
    endfunction

    function void owe(kind_e k, logic [7:0] b, logic [31:0] t, logic [31:0] l);
      result_t r;
      r.kind            = k;
      r.payload_byte    = b;
      r.message_type    = t;
      r.declared_length = l;
      owed_q.insert(owed_q.size(), r);
    endfunction

    // one accepted byte request
    function void note_byte(logic [7:0] b);
      logic [31:0] shift_amt;
      logic [31:0] pos;
      shift_amt = {27'd0, byte_pos[1:0], 3'd0};
      case (phase)
        HDR_TYPE: begin
          type_word |= 32'(b) << shift_amt;
          byte_pos++;
          if (byte_pos >= HeaderLen) phase = FRAME_BODY;
        end
        FRAME_BODY: begin
          pos = byte_pos;
          byte_pos++;
          if (pos < frame_len - TrailerLen) begin
            owe(KIND_PAYLOAD, b, type_word, frame_len);
          end else if (pos >= frame_len - 32'd1) begin
            owe(KIND_DONE, 8'd0, type_word, frame_len);
            restart();
          end
        end
        default: begin
          if (byte_pos == 0) frame_len = '0;
          frame_len |= 32'(b) << shift_amt;
          byte_pos++;
          // length is judged once, on its fourth byte
          if (byte_pos >= 32'd4) begin
            if (frame_len < MinFrameLen || frame_len > max_len) begin
              owe(KIND_BADLEN, 8'd0, 32'd0, frame_len);
              restart();
            end else begin
              type_word = '0;
              phase     = HDR_TYPE;
            end
          end
        end
      endcase
    endfunction

    // one accepted result request against the oldest owed one
    function void check_result(logic [1:0] k, logic [7:0] pb, logic [31:0] mt,
                               logic [31:0] dl);
      result_t e;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got kind %0d length %0d",
                 $time, k, dl);
        return;
      end
      e = owed_q.pop_front();
      if (k !== e.kind) begin
        errors++;
        $display("%0t: kind expected %0d got %0d", $time, e.kind, k);
      end
      if (pb !== e.payload_byte) begin
        errors++;
        $display("%0t: payload_byte expected %0h got %0h", $time, e.payload_byte, pb);
      end
      if (mt !== e.message_type) begin
        errors++;
        $display("%0t: message_type expected %0h got %0h", $time, e.message_type, mt);
      end
      if (dl !== e.declared_length) begin
        errors++;
        $display("%0t: declared_length expected %0h got %0h", $time, e.declared_length, dl);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  kind_o;
  logic [7:0]  payload_byte_o;
  logic [31:0] message_type_o;
  logic [31:0] declared_length_o;

  deframe_scoreboard sb;
  int unsigned bytes_sent;
  int unsigned idle_cycles;
  int unsigned rx_hold;
  bit          tx_burst;
  bit          rx_burst;
  logic [31:0] max_plan [8] = '{32'hFFFF_FFFF, 32'd10, 32'd300, 32'd9, 32'd0,
                                32'd64, 32'd1000, 32'hFFFF_FFFF};

  length_prefixed_frame_deframer uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .payload_byte_o   (payload_byte_o),
    .message_type_o   (message_type_o),
    .declared_length_o(declared_length_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // gap before a request; now and then switch into or out of a run with no gaps
  function automatic int unsigned draw_gap(inout bit burst);
    if ($urandom_range(0, 39) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 9);
  endfunction

  // receiver: check each accepted result, then stall a random while
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      sb.check_result(kind_o, payload_byte_o, message_type_o, declared_length_o);
      rx_hold = draw_gap(rx_burst);
    end else if (rx_hold != 0) begin
      rx_hold--;
    end
    out_stall_i <= (rx_hold != 0);
  end

  // watchdog on cycles with no request moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = draw_gap(tx_burst);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) send_byte(w[8*i +: 8]);
  endtask

  // frame with random payload and trailer, cut short after cut bytes
  task automatic send_frame(input logic [31:0] len, input logic [31:0] mtype,
                            input int unsigned cut);
    for (int unsigned n = 0; n < cut && n < len; n++) begin
      if (n < 4) send_byte(len[8*n +: 8]);
      else if (n < 8) send_byte(mtype[8*(n-4) +: 8]);
      else send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // zero fill until the parser sits at the start of a length header
  task automatic resync();
    while (!sb.at_boundary()) send_byte(8'd0);
  endtask

  // write the limit once all owed results are out and the pipe has emptied
  task automatic set_max(input logic [31:0] v);
    in_valid_i <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.max_len = v;
  endtask

  // mostly short frames, a few long ones, and lengths at and just past the limit
  function automatic logic [31:0] pick_length(input logic [31:0] max_v);
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(41, 300);
    if (r == 1 && max_v >= MinFrameLen && max_v <= 300) return max_v;
    if (r == 2 && max_v >= MinFrameLen && max_v < 300) return max_v + 1;
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] bad_length(input logic [31:0] max_v);
    logic [31:0] v;
    int unsigned r;
    r = $urandom_range(0, 3);
    if (max_v == MaxFrameRst || r == 0) return $urandom_range(0, 9);
    if (r == 1) return MaxFrameRst;
    v = $urandom;
    if (v >= MinFrameLen && v <= max_v) v = max_v + 1;
    return v;
  endfunction

  // one limit setting: good frames, bad lengths, cut frames and raw noise;
  // noise only while the limit keeps any stray length short
  task automatic run_phase(input logic [31:0] max_v);
    int unsigned start;
    int unsigned pick;
    logic [31:0] len;
    bit          noisy;
    // close any partial header while the old limit still applies
    resync();
    set_max(max_v);
    noisy = (max_v <= NoiseMaxLimit);
    start = bytes_sent;
    while (bytes_sent - start < PhaseBytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 70 || (!noisy && pick >= 85)) begin
        resync();
        len = pick_length(max_v);
        send_frame(len, $urandom, len);
      end else if (pick < 80) begin
        resync();
        send_word(bad_length(max_v));
      end else if (pick < 85) begin
        resync();
        len = pick_length(max_v);
        send_frame(len, $urandom, $urandom_range(1, len - 1));
      end else begin
        repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    sb          = new();
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    data_byte_i = '0;
    out_stall_i = 1'b0;
    rx_hold     = 0;
    idle_cycles = 0;
    bytes_sent  = 0;
    tx_burst    = 1'b0;
    rx_burst    = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_max(MaxFrameRst);

    // empty payload with an all-ones type, zero length, one 0xff payload byte
    send_frame(32'd10, 32'hFFFF_FFFF, 10);
    send_word(32'd0);
    send_word(32'd11);
    send_word(32'd0);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);

    foreach (max_plan[i]) run_phase(max_plan[i]);

    // drain and let any stray result show up
    in_valid_i <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
